// ===== rtl/pctq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the paced chunk transmit queue.
// Depends on nothing; pctq_if and the top level import it.
package pctq_pkg;

    localparam int QUEUE_CHUNKS_DEF = 16;
    localparam int CHUNK_BYTES_DEF  = 20;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DEPTH_W    = 5;

    // request action codes
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_BYTE       = 3'd1;
    localparam logic [2:0] ACT_CONNECT    = 3'd2;
    localparam logic [2:0] ACT_DISCONNECT = 3'd3;
    localparam logic [2:0] ACT_CMD_START  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT   = 2'd2;

    localparam logic [15:0] SEND_INTERVAL_RST = 16'd50;
    localparam logic [15:0] COOLDOWN_RST      = 16'd100;
    localparam logic [7:0]  BURST_LIMIT_RST   = 8'd8;

    // result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       line_end;
        logic       subscribed;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic [7:0]         out_byte;
        logic               chunk_last;
        logic [15:0]        chunks_sent;
        logic [DEPTH_W-1:0] peak_depth;
        logic [DEPTH_W-1:0] lifetime_peak;
        logic [31:0]        drain_time;
        logic [15:0]        overflow_count;
    } t_rsp;

endpackage
`default_nettype wire

// ===== rtl/pctq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for requests and results.
// Depends on pctq_pkg for the payload types.
interface pctq_req_if import pctq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pctq_rsp_if import pctq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pctq_chunk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Chunk byte store: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module pctq_chunk_ram #(
    parameter int DEPTH  = 320,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/paced_chunk_transmit_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake        Carries
// i_req     in   valid/ready      action, data_byte, line_end, subscribed
// o_rsp     out  valid/ready      sent chunk bytes and drain summaries
// i_cfg_*   in   write enable     send_interval_ms, cooldown_ms, burst_limit
//
// A tick with a send reads the chunk length, then each chunk byte (store read,
// then output register), then emits a summary if one is due. A line byte that
// closes a chunk copies the assembly buffer into the store. Requests are
// taken only in the idle state. Reset is synchronous; the memories are not
// cleared. A stalled o_rsp holds the sequencer in place.
//
// Top level of the paced chunk transmit queue.
// Depends on pctq_pkg, pctq_if and pctq_chunk_ram.
module paced_chunk_transmit_queue import pctq_pkg::*; #(
    parameter int QUEUE_CHUNKS = QUEUE_CHUNKS_DEF,
    parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pctq_req_if.sink                  i_req,
    pctq_rsp_if.source                o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int OCC_W       = $clog2(QUEUE_CHUNKS + 1);
    localparam int IDX_W       = $clog2(QUEUE_CHUNKS);
    localparam int LEN_W       = $clog2(CHUNK_BYTES + 1);
    localparam int AIDX_W      = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int STORE_DEPTH = QUEUE_CHUNKS * CHUNK_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CPWAIT = 7'b0000010,
        ST_COPY   = 7'b0000100,
        ST_LEN    = 7'b0001000,
        ST_EMIT   = 7'b0010000,
        ST_FETCH  = 7'b0100000,
        ST_SUM    = 7'b1000000
    } t_state;

    // control state
    t_state             r_state, n_state;
    logic [15:0]        r_send_interval, n_send_interval;
    logic [15:0]        r_cooldown, n_cooldown;
    logic [7:0]         r_burst_limit, n_burst_limit;
    logic [LEN_W-1:0]   r_asm_count, n_asm_count;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic               r_connected, n_connected;
    logic [7:0]         r_burst, n_burst;
    logic [15:0]        r_ms, n_ms;
    logic               r_draining, n_draining;
    logic [15:0]        r_resp_chunks, n_resp_chunks;
    logic [OCC_W-1:0]   r_resp_peak, n_resp_peak;
    logic [OCC_W-1:0]   r_life_peak, n_life_peak;
    logic [15:0]        r_dropped, n_dropped;
    logic [31:0]        r_drain_timer, n_drain_timer;
    logic               r_sum_pend, n_sum_pend;
    logic               r_out_valid, n_out_valid;

    // sequencer payload
    logic [AIDX_W-1:0]  r_asm_raddr, n_asm_raddr;
    logic [ADDR_W-1:0]  r_cp_addr, n_cp_addr;
    logic [LEN_W-1:0]   r_cp_left, n_cp_left;
    logic [ADDR_W-1:0]  r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0]   r_send_len, n_send_len;
    logic [LEN_W-1:0]   r_send_idx, n_send_idx;
    logic [15:0]        r_sum_chunks, n_sum_chunks;
    logic [OCC_W-1:0]   r_sum_peak, n_sum_peak;
    logic [OCC_W-1:0]   r_sum_life, n_sum_life;
    logic [31:0]        r_sum_timer, n_sum_timer;
    logic [15:0]        r_sum_dropped, n_sum_dropped;
    t_rsp               r_out, n_out;

    // memories
    logic [7:0]         asm_mem [CHUNK_BYTES];
    logic [LEN_W-1:0]   len_mem [QUEUE_CHUNKS];
    logic [7:0]         r_asm_q;
    logic [LEN_W-1:0]   r_len_q;

    logic               asm_we;
    logic               len_we;
    logic [LEN_W-1:0]   cnt_new;
    logic               store_we;
    logic [7:0]         store_rdata;

    logic               accept;
    logic               out_free;
    logic               cool;
    logic [15:0]        spacing;
    logic [15:0]        ms_inc;
    logic [7:0]         burst_tmp;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_next;
    logic [OCC_W-1:0]   occ_inc;
    logic               last_byte;

    assign accept   = i_req.valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign cool      = (r_burst >= r_burst_limit);
    assign spacing   = cool ? r_cooldown : r_send_interval;
    assign ms_inc    = (r_ms != 16'hFFFF) ? r_ms + 16'd1 : r_ms;
    assign head_next = (r_head == IDX_W'(QUEUE_CHUNKS - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == IDX_W'(QUEUE_CHUNKS - 1)) ? '0 : r_tail + 1'b1;
    assign occ_inc   = r_occ + 1'b1;
    assign last_byte = (r_send_idx == r_send_len - 1'b1);

    assign asm_we  = accept && (i_req.data.action == ACT_BYTE)
                     && (r_asm_count < LEN_W'(CHUNK_BYTES));
    assign cnt_new = asm_we ? r_asm_count + 1'b1 : r_asm_count;

    always_comb begin
        n_state         = r_state;
        n_send_interval = r_send_interval;
        n_cooldown      = r_cooldown;
        n_burst_limit   = r_burst_limit;
        n_asm_count     = r_asm_count;
        n_head          = r_head;
        n_tail          = r_tail;
        n_occ           = r_occ;
        n_connected     = r_connected;
        n_burst         = r_burst;
        n_ms            = r_ms;
        n_draining      = r_draining;
        n_resp_chunks   = r_resp_chunks;
        n_resp_peak     = r_resp_peak;
        n_life_peak     = r_life_peak;
        n_dropped       = r_dropped;
        n_drain_timer   = r_drain_timer;
        n_sum_pend      = r_sum_pend;
        n_out_valid     = r_out_valid && !o_rsp.ready;
        n_asm_raddr     = r_asm_raddr;
        n_cp_addr       = r_cp_addr;
        n_cp_left       = r_cp_left;
        n_rd_addr       = r_rd_addr;
        n_send_len      = r_send_len;
        n_send_idx      = r_send_idx;
        n_sum_chunks    = r_sum_chunks;
        n_sum_peak      = r_sum_peak;
        n_sum_life      = r_sum_life;
        n_sum_timer     = r_sum_timer;
        n_sum_dropped   = r_sum_dropped;
        n_out           = r_out;
        len_we          = 1'b0;
        store_we        = 1'b0;
        burst_tmp       = r_burst;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEND_INTERVAL: n_send_interval = i_cfg_wdata[15:0];
                REG_COOLDOWN:      n_cooldown      = i_cfg_wdata[15:0];
                REG_BURST_LIMIT:   n_burst_limit   = i_cfg_wdata[7:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.data.action)
                        ACT_TICK: begin
                            n_ms = ms_inc;
                            if (r_draining && (r_drain_timer != 32'hFFFF_FFFF)) begin
                                n_drain_timer = r_drain_timer + 32'd1;
                            end
                            if (r_connected && (r_occ != '0) && (ms_inc >= spacing)) begin
                                n_ms      = '0;
                                burst_tmp = cool ? 8'd0 : r_burst;
                                n_burst   = burst_tmp;
                                if (i_req.data.subscribed) begin
                                    n_head = head_next;
                                    n_occ  = r_occ - 1'b1;
                                    n_burst = (burst_tmp != 8'hFF) ? burst_tmp + 8'd1
                                                                   : burst_tmp;
                                    if (r_resp_chunks != 16'hFFFF) begin
                                        n_resp_chunks = r_resp_chunks + 16'd1;
                                    end
                                    // read address for the head chunk, length read
                                    // of the old head lands in r_len_q at this edge
                                    n_rd_addr  = ADDR_W'(r_head) * ADDR_W'(CHUNK_BYTES);
                                    n_send_idx = '0;
                                    n_state    = ST_LEN;
                                    n_sum_pend = 1'b0;
                                    if ((r_occ == OCC_W'(1)) && r_draining) begin
                                        n_sum_pend    = 1'b1;
                                        n_draining    = 1'b0;
                                        n_burst       = 8'd0;
                                        n_sum_chunks  = n_resp_chunks;
                                        n_sum_peak    = r_resp_peak;
                                        n_sum_life    = r_life_peak;
                                        n_sum_timer   = n_drain_timer;
                                        n_sum_dropped = r_dropped;
                                        n_resp_peak   = '0;
                                        n_dropped     = '0;
                                    end
                                end
                            end
                        end
                        ACT_BYTE: begin
                            n_asm_count = cnt_new;
                            if ((cnt_new >= LEN_W'(CHUNK_BYTES)) || i_req.data.line_end) begin
                                n_asm_count = '0;
                                if (r_occ >= OCC_W'(QUEUE_CHUNKS)) begin
                                    if (r_dropped != 16'hFFFF) begin
                                        n_dropped = r_dropped + 16'd1;
                                    end
                                end else begin
                                    len_we      = 1'b1;
                                    n_tail      = tail_next;
                                    n_occ       = occ_inc;
                                    if (occ_inc > r_resp_peak) begin
                                        n_resp_peak = occ_inc;
                                    end
                                    if (occ_inc > r_life_peak) begin
                                        n_life_peak = occ_inc;
                                    end
                                    n_cp_addr   = ADDR_W'(r_tail) * ADDR_W'(CHUNK_BYTES);
                                    n_cp_left   = cnt_new;
                                    n_asm_raddr = '0;
                                    n_state     = ST_CPWAIT;
                                end
                            end
                        end
                        ACT_CONNECT: begin
                            n_connected = 1'b1;
                            n_head      = '0;
                            n_tail      = '0;
                            n_occ       = '0;
                            n_burst     = '0;
                            n_draining  = 1'b0;
                            n_resp_peak = '0;
                        end
                        ACT_DISCONNECT: begin
                            n_connected = 1'b0;
                            n_head      = '0;
                            n_tail      = '0;
                            n_occ       = '0;
                            n_burst     = '0;
                            n_draining  = 1'b0;
                        end
                        ACT_CMD_START: begin
                            n_draining    = 1'b1;
                            n_drain_timer = '0;
                            n_resp_chunks = '0;
                            n_resp_peak   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CPWAIT: begin
                // assembly byte 0 is being read this cycle
                n_asm_raddr = r_asm_raddr + 1'b1;
                n_state     = ST_COPY;
            end
            ST_COPY: begin
                store_we  = 1'b1;
                n_cp_addr = r_cp_addr + 1'b1;
                n_cp_left = r_cp_left - 1'b1;
                if (r_asm_raddr != AIDX_W'(CHUNK_BYTES - 1)) begin
                    n_asm_raddr = r_asm_raddr + 1'b1;
                end
                if (r_cp_left == LEN_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LEN: begin
                n_send_len = r_len_q;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.kind     = KIND_BYTE;
                    n_out.out_byte = store_rdata;
                    n_out.chunk_last = last_byte && !r_sum_pend;
                    if (last_byte) begin
                        n_state = r_sum_pend ? ST_SUM : ST_IDLE;
                    end else begin
                        n_send_idx = r_send_idx + 1'b1;
                        n_rd_addr  = r_rd_addr + 1'b1;
                        n_state    = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_SUM: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = KIND_SUMMARY;
                    n_out.out_byte       = '0;
                    n_out.chunk_last     = 1'b1;
                    n_out.chunks_sent    = r_sum_chunks;
                    n_out.peak_depth     = DEPTH_W'(r_sum_peak);
                    n_out.lifetime_peak  = DEPTH_W'(r_sum_life);
                    n_out.drain_time     = r_sum_timer;
                    n_out.overflow_count = r_sum_dropped;
                    n_sum_pend           = 1'b0;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_send_interval <= SEND_INTERVAL_RST;
            r_cooldown      <= COOLDOWN_RST;
            r_burst_limit   <= BURST_LIMIT_RST;
            r_asm_count     <= '0;
            r_head          <= '0;
            r_tail          <= '0;
            r_occ           <= '0;
            r_connected     <= 1'b0;
            r_burst         <= '0;
            r_ms            <= 16'hFFFF;
            r_draining      <= 1'b0;
            r_resp_chunks   <= '0;
            r_resp_peak     <= '0;
            r_life_peak     <= '0;
            r_dropped       <= '0;
            r_drain_timer   <= '0;
            r_sum_pend      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_send_interval <= n_send_interval;
            r_cooldown      <= n_cooldown;
            r_burst_limit   <= n_burst_limit;
            r_asm_count     <= n_asm_count;
            r_head          <= n_head;
            r_tail          <= n_tail;
            r_occ           <= n_occ;
            r_connected     <= n_connected;
            r_burst         <= n_burst;
            r_ms            <= n_ms;
            r_draining      <= n_draining;
            r_resp_chunks   <= n_resp_chunks;
            r_resp_peak     <= n_resp_peak;
            r_life_peak     <= n_life_peak;
            r_dropped       <= n_dropped;
            r_drain_timer   <= n_drain_timer;
            r_sum_pend      <= n_sum_pend;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm_raddr   <= n_asm_raddr;
        r_cp_addr     <= n_cp_addr;
        r_cp_left     <= n_cp_left;
        r_rd_addr     <= n_rd_addr;
        r_send_len    <= n_send_len;
        r_send_idx    <= n_send_idx;
        r_sum_chunks  <= n_sum_chunks;
        r_sum_peak    <= n_sum_peak;
        r_sum_life    <= n_sum_life;
        r_sum_timer   <= n_sum_timer;
        r_sum_dropped <= n_sum_dropped;
        r_out         <= n_out;
    end

    // assembly buffer: written at the fill count, read by the copy sweep
    always_ff @(posedge i_clk) begin
        if (asm_we) begin
            asm_mem[r_asm_count[AIDX_W-1:0]] <= i_req.data.data_byte;
        end
        r_asm_q <= asm_mem[r_asm_raddr];
    end

    // chunk lengths: written at the tail on push, read at the head
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[r_tail] <= cnt_new;
        end
        r_len_q <= len_mem[r_head];
    end

    pctq_chunk_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cp_addr),
        .i_wdata (r_asm_q),
        .i_raddr (r_rd_addr),
        .o_rdata (store_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule
`default_nettype wire
